// ===== rtl/core/pipo_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pipo_pkg: shared types, constants and round functions
// Block layout, key register indexes and the bitsliced S-layer / rotation
// layer used by every round cell.
// ----------------------------------------------------------------------------
package pipo_pkg;

  localparam int BLOCK_W         = 64;
  localparam int NUM_KEYS        = 4;
  localparam int KEY_SEL_W       = $clog2(NUM_KEYS);
  localparam int CFG_IDX_W       = 8;
  localparam int ROUND_CONST_W   = 8;
  localparam int NUM_ROUNDS_DEF  = 17;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_0 = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_1 = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_2 = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_3 = CFG_IDX_W'(3);

  typedef logic [BLOCK_W-1:0] block_t;
  typedef block_t [NUM_KEYS-1:0] key_set_t;

  // one link of the cell chain
  typedef struct packed {
    logic   valid;
    block_t blk;
  } stage_t;

  function automatic logic [7:0] rotl8(input logic [7:0] v, input int s);
    rotl8 = (v << s) | (v >> (8 - s));
  endfunction

  function automatic block_t sbox_layer(input block_t w);
    logic [7:0] x [0:7];
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] c;
    block_t     res;
    for (int i = 0; i < 8; i++) begin
      x[i] = w[8*i +: 8];
    end
    // first 5-bit part on rows 3..7
    x[7] = x[7] ^ (x[5] & x[6]);
    x[4] = x[4] ^ (x[5] & x[7]);
    x[5] = x[5] ^ (x[4] | x[3]);
    x[6] = x[6] ^ x[4];
    x[3] = x[3] ^ x[7];
    x[7] = x[7] ^ (x[3] & x[6]);
    // 3-bit part on rows 0..2
    x[0] = x[0] ^ (x[2] & x[1]);
    x[1] = ~(x[1] ^ (x[2] | x[0]));
    x[2] = x[2] ^ (x[0] | x[1]);
    x[7] = x[7] ^ x[2];
    x[6] = x[6] ^ x[1];
    x[5] = x[5] ^ x[0];
    // second 5-bit part
    a = x[7];
    b = x[6];
    c = x[5];
    x[4] = x[4] ^ (x[3] & a);
    x[4] = x[4] ^ b;
    c = c ^ (x[4] | b);
    a = a ^ c;
    b = b ^ x[3];
    c = c | b;
    x[3] = x[3] ^ (x[4] | a);
    c = c ^ a;
    x[2] = x[2] ^ a;
    x[1] = x[1] ^ c;
    x[0] = x[0] ^ b;
    for (int i = 0; i < 8; i++) begin
      res[8*i +: 8] = x[i];
    end
    sbox_layer = res;
  endfunction

  function automatic block_t perm_layer(input block_t w);
    block_t res;
    res[7:0]   = w[7:0];
    res[15:8]  = rotl8(w[15:8], 4);
    res[23:16] = rotl8(w[23:16], 1);
    res[31:24] = rotl8(w[31:24], 7);
    res[39:32] = rotl8(w[39:32], 6);
    res[47:40] = rotl8(w[47:40], 2);
    res[55:48] = rotl8(w[55:48], 3);
    res[63:56] = rotl8(w[63:56], 5);
    perm_layer = res;
  endfunction

endpackage

// ===== rtl/core/pipo_round_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pipo_round_cell: one registered cipher round
// S-layer, row rotations, round number into byte 0 and round key XOR,
// then a register that hands the item to the next cell.
// ----------------------------------------------------------------------------
module pipo_round_cell
  import pipo_pkg::*;
#(
  parameter int ROUND = 1
) (
  input  logic     clk,
  input  logic     rst_n,
  input  stage_t   stage_in,
  input  key_set_t keys,
  output stage_t   stage_out
);

  localparam logic [KEY_SEL_W-1:0]     KEY_SEL = KEY_SEL_W'(ROUND % NUM_KEYS);
  localparam logic [ROUND_CONST_W-1:0] RC      = ROUND_CONST_W'(ROUND);

  logic   valid_r;
  logic   valid_nxt;
  block_t blk_r;
  block_t blk_nxt;
  block_t mixed;

  always_comb begin
    mixed     = perm_layer(sbox_layer(stage_in.blk));
    blk_nxt   = mixed ^ {{(BLOCK_W-ROUND_CONST_W){1'b0}}, RC} ^ keys[KEY_SEL];
    valid_nxt = stage_in.valid;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    blk_r <= blk_nxt;
  end

  assign stage_out.valid = valid_r;
  assign stage_out.blk   = blk_r;

endmodule

// ===== rtl/core/pipo_64_256_block_encrypt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pipo_64_256_block_encrypt: pipelined 64-bit block cipher, 256-bit key
// Whitening register followed by a chain of NUM_ROUNDS round cells.
// ----------------------------------------------------------------------------
// Usage:
//   Key: write the four 64-bit key words through cfg_valid/cfg_ready with
//   cfg_index 0..3 and cfg_data; cfg_ready goes high in the cycle after reset
//   is released and stays high. Writes to other indexes are dropped.
//   The user must change keys only while idle; the block does not enforce it.
//   Input: an item is taken on each clock edge with start high and busy low.
//   busy is high during reset, drops in the cycle after its release and
//   then stays low, so one block enters per cycle.
//   Output: ciphertext appears on out_ciphertext with out_valid high for one
//   cycle, once the item has passed the whitening register and then the
//   register in each round cell.
//   Throughput is one item per cycle, set by the one-round-per-cell chain.
//   The receiver cannot stall; results are not held.
//   Reset clears the key words to zero and all valid flags in the chain;
//   items in flight at reset are lost.
// ----------------------------------------------------------------------------
module pipo_64_256_block_encrypt
  import pipo_pkg::*;
#(
  parameter int NUM_ROUNDS = NUM_ROUNDS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [BLOCK_W-1:0]   in_plaintext,
  output logic                 out_valid,
  output logic [BLOCK_W-1:0]   out_ciphertext,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BLOCK_W-1:0]   cfg_data
);

  key_set_t key_r;
  logic     busy_r;
  logic     wht_valid_r;
  block_t   wht_blk_r;
  stage_t   chain [0:NUM_ROUNDS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r  <= '0;
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_KEY_WORD_0: key_r[0] <= cfg_data;
          REG_KEY_WORD_1: key_r[1] <= cfg_data;
          REG_KEY_WORD_2: key_r[2] <= cfg_data;
          REG_KEY_WORD_3: key_r[3] <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  assign busy      = busy_r;
  assign cfg_ready = !busy_r;

  // whitening stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wht_valid_r <= 1'b0;
    end else begin
      wht_valid_r <= start && !busy_r;
    end
  end

  always_ff @(posedge clk) begin
    wht_blk_r <= in_plaintext ^ key_r[0];
  end

  assign chain[0].valid = wht_valid_r;
  assign chain[0].blk   = wht_blk_r;

  for (genvar r = 1; r <= NUM_ROUNDS; r++) begin : g_round
    pipo_round_cell #(
      .ROUND(r)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .stage_in (chain[r-1]),
      .keys     (key_r),
      .stage_out(chain[r])
    );
  end

  assign out_valid      = chain[NUM_ROUNDS].valid;
  assign out_ciphertext = chain[NUM_ROUNDS].blk;

endmodule

// ===== rtl/core/pipo_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pipo_chk: port-level checks for the block encryptor
// Fixed latency between accepted items and results, busy and cfg_ready
// behavior after reset.
// ----------------------------------------------------------------------------
module pipo_chk
  import pipo_pkg::*;
#(
  parameter int NUM_ROUNDS = NUM_ROUNDS_DEF
) (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 start,
  input logic                 busy,
  input logic                 out_valid,
  input logic                 cfg_ready
);

  localparam int LAT = NUM_ROUNDS + 1;

  // every accepted item gives a result after the fixed latency
  a_latency : assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LAT out_valid)
    else $error("result missing after accepted item");

  // no result without an item accepted the latency earlier
  a_no_spurious : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LAT))
    else $error("result without accepted item");

  // when reset was also released in the previous cycle, the block takes items
  a_not_busy : assert property (@(posedge clk)
    (rst_n && $past(rst_n)) |-> !busy)
    else $error("busy high outside reset");

  a_cfg_ready : assert property (@(posedge clk)
    (rst_n && $past(rst_n)) |-> cfg_ready)
    else $error("cfg_ready low outside reset");

endmodule

bind pipo_64_256_block_encrypt pipo_chk #(
  .NUM_ROUNDS(NUM_ROUNDS)
) u_pipo_chk (
  .clk      (clk),
  .rst_n    (rst_n),
  .start    (start),
  .busy     (busy),
  .out_valid(out_valid),
  .cfg_ready(cfg_ready)
);
